FILE: rtl/swm_pkg.sv
// swm_pkg: shared types and constants for the sliding window maximum block
// no dependencies; used by the cell and the top level by scoped names
package swm_pkg;

    // width of the window size register, and its value after reset
    localparam int unsigned CFG_BITS     = 7;
    localparam int unsigned WINDOW_RESET = 3;

    // per-cell control: shift a new sample in, restart the sequence, copy the left cell
    typedef struct packed {
        logic step;
        logic start;
        logic copy;
    } swm_cell_ctrl_t;

endpackage

FILE: rtl/swm_if.sv
// swm_in_if / swm_out_if: valid-ready channels for samples and window maxima
// standalone; instantiated around sliding_window_maximum_top
interface swm_in_if #(
    parameter int unsigned SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          start_of_sequence;

    modport source (output valid, output sample, output start_of_sequence, input ready);
    modport sink   (input valid, input sample, input start_of_sequence, output ready);
endinterface

interface swm_out_if #(
    parameter int unsigned SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] window_max;

    modport source (output valid, output window_max, input ready);
    modport sink   (input valid, input window_max, output ready);
endinterface

FILE: rtl/swm_cell.sv
// swm_cell: one cell of the running maximum chain
// holds the oldest live deque value among positions up to its own; uses swm_pkg
module swm_cell #(
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  swm_pkg::swm_cell_ctrl_t       ctrl,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          left_valid,
    input  logic signed [SAMPLE_BITS-1:0] left_value,
    output logic                          valid,
    output logic signed [SAMPLE_BITS-1:0] value
);

    logic                          valid_reg;
    logic                          valid_next;
    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic signed [SAMPLE_BITS-1:0] value_next;
    logic                          keep_left;

    // the left front survives unless the new sample beats it or the sequence restarts
    assign keep_left = left_valid && !ctrl.start && (left_value >= sample);

    // next state of the cell
    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.step)
        begin
            valid_next = 1'b1;
            value_next = keep_left ? left_value : sample;
        end
        else if (ctrl.copy)
        begin
            valid_next = left_valid;
            value_next = left_value;
        end
    end

    // valid flag cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;

endmodule

FILE: rtl/sliding_window_maximum_top.sv
// sliding_window_maximum_top: running maximum over the last window_size samples
// depends on swm_pkg, swm_if (swm_in_if, swm_out_if) and swm_cell
//
//   channel     dir  handshake       payload
//   sample_ch   in   valid/ready     sample, start_of_sequence
//   max_ch      out  valid/ready     window_max
//   cfg         in   cfg_we          cfg_wdata (window_size)
//
// one sample per clock while ready is high; a result leaves through a single output
// register in the cycle after its sample is taken, and a new sample can enter in the
// cycle the waiting result is taken.
// cell k holds the front of the deque restricted to ages 0..k; the result is
// formed from cell window_size-2 and the new sample through one select and one compare.
// after reset the block is ready at once; after a window size write it holds
// ready low until the settle counter runs down, while the cells past the old window settle.
// a stalled output stops input only when the output register is still full.
module sliding_window_maximum_top #(
    parameter int unsigned WINDOW_MAX  = 64,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [swm_pkg::CFG_BITS-1:0]     cfg_wdata,
    swm_in_if.sink                           sample_ch,
    swm_out_if.source                        max_ch
);

    localparam int unsigned WB = $clog2(WINDOW_MAX + 1);
    localparam int unsigned CW = (WB > swm_pkg::CFG_BITS) ? WB : swm_pkg::CFG_BITS;
    localparam int unsigned IW = $clog2((WINDOW_MAX > 1) ? WINDOW_MAX : 2);

    logic [swm_pkg::CFG_BITS-1:0]  window_size_reg;
    logic [WB-1:0]                 w_used_reg;
    logic [WB-1:0]                 seen_reg;
    logic [WB-1:0]                 seen_next;
    logic [WB-1:0]                 settle_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_data_reg;

    logic [CW-1:0]                 ws_ext;
    logic [CW-1:0]                 w_wide;
    logic [WB-1:0]                 w_eff;
    logic [WB-1:0]                 w_minus2;
    logic [IW-1:0]                 sel;
    logic                          busy;
    logic                          step;
    logic                          emit;
    logic                          prev_ok;
    logic signed [SAMPLE_BITS-1:0] result;

    logic                          cell_valid [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] cell_value [WINDOW_MAX];

    // effective window: zero counts as one, large values clamp to the cell count
    assign ws_ext = CW'(window_size_reg);
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            w_wide = CW'(1);
        end
        else if (ws_ext > CW'(WINDOW_MAX))
        begin
            w_wide = CW'(WINDOW_MAX);
        end
        else
        begin
            w_wide = ws_ext;
        end
    end
    assign w_eff = w_wide[WB-1:0];

    // handshake
    assign busy            = (settle_reg != '0);
    assign sample_ch.ready = !busy && (!out_valid_reg || max_ch.ready);
    assign step            = sample_ch.valid && sample_ch.ready;

    // front of the new window from the cell one position short of it
    assign w_minus2 = w_eff - WB'(2);
    assign sel      = w_minus2[IW-1:0];
    assign prev_ok  = (w_eff != WB'(1)) && !sample_ch.start_of_sequence
                      && cell_valid[sel] && (cell_value[sel] >= sample_ch.sample);
    assign result   = prev_ok ? cell_value[sel] : sample_ch.sample;

    // saturating sample count of the current sequence
    always_comb
    begin
        if (sample_ch.start_of_sequence)
        begin
            seen_next = WB'(1);
        end
        else if (seen_reg < WB'(WINDOW_MAX))
        begin
            seen_next = seen_reg + WB'(1);
        end
        else
        begin
            seen_next = seen_reg;
        end
    end
    assign emit = step && (seen_next >= w_eff);

    // row of cells
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        swm_pkg::swm_cell_ctrl_t       ctrl;
        logic                          left_valid;
        logic signed [SAMPLE_BITS-1:0] left_value;

        assign ctrl.step  = step;
        assign ctrl.start = sample_ch.start_of_sequence;
        assign ctrl.copy  = busy && (WB'(i) >= w_used_reg);

        if (i == 0)
        begin : g_head
            assign left_valid = 1'b0;
            assign left_value = '0;
        end
        else
        begin : g_body
            assign left_valid = cell_valid[i-1];
            assign left_value = cell_value[i-1];
        end

        swm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .sample     (sample_ch.sample),
            .left_valid (left_valid),
            .left_value (left_value),
            .valid      (cell_valid[i]),
            .value      (cell_value[i])
        );
    end

    // control registers: window size, count, settle timer, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= swm_pkg::CFG_BITS'(swm_pkg::WINDOW_RESET);
            w_used_reg      <= WB'(1);
            seen_reg        <= '0;
            settle_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_size_reg <= cfg_wdata;
                settle_reg      <= WB'(WINDOW_MAX);
            end
            else if (busy)
            begin
                settle_reg <= settle_reg - WB'(1);
            end
            if (step)
            begin
                seen_reg   <= seen_next;
                w_used_reg <= w_eff;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (max_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= result;
        end
    end

    assign max_ch.valid      = out_valid_reg;
    assign max_ch.window_max = out_data_reg;

endmodule

FILE: test/tb_top.sv
// tb_top: self-checking bench for sliding_window_maximum_top, with a deque-based
// window maximum predictor, random idling on both channels and window size changes
// depends on swm_pkg, swm_in_if, swm_out_if and sliding_window_maximum_top
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WINDOW_MAX   = 64;
    localparam int unsigned SAMPLE_BITS  = 16;
    localparam int          SETTLE_WAIT  = WINDOW_MAX + 8;
    localparam int          HOLD_CYCLES  = 200;
    localparam int          RANDOM_ITEMS = 1450;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [swm_pkg::CFG_BITS-1:0]  cfg_word_t;

    // expected result, tagged with the request that caused it
    typedef struct {
        int unsigned request_no;
        sample_t     window_max;
    } max_expect_t;

    typedef enum int {
        SHAPE_UNIFORM,
        SHAPE_FALLING,
        SHAPE_RISING,
        SHAPE_PLATEAU,
        SHAPE_NARROW
    } stream_shape_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_word_t cfg_wdata;

    swm_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
    swm_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) max_ch ();

    sliding_window_maximum_top #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sample_ch (sample_ch),
        .max_ch    (max_ch)
    );

    // predictor state: monotonic deque, front (oldest) at index 0
    sample_t             dq_value [WINDOW_MAX];
    int unsigned         dq_age [WINDOW_MAX];
    int unsigned         dq_len;
    int unsigned         seq_samples;
    cfg_word_t           window_reg;

    max_expect_t pending_max[$];
    int unsigned requests_sent;
    int unsigned mismatch_count;
    bit          in_gaps_on;
    bit          out_stall_on;
    bit          hold_request;
    bit          hold_active;

    // clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // overall time limit
    initial
    begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // window maximum after taking one sample; returns 1 when a result is due
    function automatic bit predict_window_max(input sample_t value, input logic restart,
                                              output sample_t peak);
        int unsigned win;
        int unsigned drop;
        win = (window_reg == 0) ? 1 : ((window_reg > WINDOW_MAX) ? WINDOW_MAX : window_reg);
        peak = '0;
        if (restart)
        begin
            dq_len = 0;
            seq_samples = 0;
        end
        for (int i = 0; i < dq_len; i++)
            if (dq_age[i] < WINDOW_MAX)
                dq_age[i]++;
        // aged-out entries leave from the front
        drop = 0;
        while (drop < dq_len && dq_age[drop] >= win)
            drop++;
        for (int i = 0; i + drop < dq_len; i++)
        begin
            dq_value[i] = dq_value[i + drop];
            dq_age[i]   = dq_age[i + drop];
        end
        dq_len -= drop;
        // strictly smaller entries leave from the back, equal ones stay
        while (dq_len > 0 && dq_value[dq_len - 1] < value)
            dq_len--;
        if (dq_len < WINDOW_MAX)
        begin
            dq_value[dq_len] = value;
            dq_age[dq_len]   = 0;
            dq_len++;
        end
        if (seq_samples < WINDOW_MAX)
            seq_samples++;
        if (seq_samples >= win && dq_len > 0)
        begin
            peak = dq_value[0];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // idle length: mostly none or short, a few long
    function automatic int pick_idle(input bit enabled);
        int unsigned r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // offer one request and wait for it to be taken
    task automatic send_sample(input sample_t value, input logic restart);
        sample_t     peak;
        int          gap;
        max_expect_t due;
        sample_ch.valid             <= 1'b1;
        sample_ch.sample            <= value;
        sample_ch.start_of_sequence <= restart;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        requests_sent++;
        if (predict_window_max(value, restart, peak))
        begin
            due.request_no = requests_sent;
            due.window_max = peak;
            pending_max    = {pending_max, due};
        end
        gap = pick_idle(in_gaps_on);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering, wait for every result, then let the block settle
    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        while (pending_max.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_window(input cfg_word_t value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        window_reg = value;
    endtask

    // next sample of a shaped stream, clamped to the sample range
    function automatic int next_sample(input stream_shape_t shape, input int prev);
        int v;
        case (shape)
            SHAPE_FALLING: v = prev - int'($urandom_range(0, 2000));
            SHAPE_RISING:  v = prev + int'($urandom_range(0, 2000));
            SHAPE_PLATEAU: v = ($urandom_range(0, 3) == 0) ? prev + int'($urandom_range(0, 2)) - 1
                                                           : prev;
            SHAPE_NARROW:  v = int'($urandom_range(0, 6)) - 3;
            default:       v = int'($signed(sample_t'($urandom)));
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v;
    endfunction

    // checker: each result against the oldest expectation
    always @(posedge clk)
    begin
        max_expect_t exp_item;
        if (rst_n && max_ch.valid && max_ch.ready)
        begin
            if (pending_max.size() == 0)
                report_mismatch($sformatf("window_max %0d with no result expected",
                                          max_ch.window_max));
            else
            begin
                exp_item = pending_max[0];
                pending_max.delete(0);
                if (max_ch.window_max !== exp_item.window_max)
                    report_mismatch($sformatf("request %0d: window_max %0d, expected %0d",
                                              exp_item.request_no, max_ch.window_max,
                                              exp_item.window_max));
            end
        end
    end

    // receiver: random stalls, long hold-off on request
    initial
    begin
        int stall;
        max_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request  = 1'b0;
                hold_active   = 1'b1;
                max_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
            end
            else
            begin
                stall = pick_idle(out_stall_on);
                if (stall > 0)
                begin
                    max_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            max_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // reset value of the window: extremes, equal values, restart mid-stream
    task automatic test_reset_window();
        send_sample(sample_t'(-32768), 1'b1);
        send_sample(sample_t'(32767), 1'b0);
        send_sample(sample_t'(0), 1'b0);
        send_sample(sample_t'(-1), 1'b0);
        send_sample(sample_t'(5), 1'b0);
        send_sample(sample_t'(5), 1'b0);
        send_sample(sample_t'(5), 1'b0);
        send_sample(sample_t'(-32768), 1'b0);
        send_sample(sample_t'(-32768), 1'b0);
        send_sample(sample_t'(-32768), 1'b0);
        send_sample(sample_t'(1), 1'b1);
        send_sample(sample_t'(2), 1'b0);
        send_sample(sample_t'(3), 1'b0);
    endtask

    // window of one, and zero which acts as one
    task automatic test_tiny_windows();
        write_window(cfg_word_t'(1));
        send_sample(sample_t'(32767), 1'b0);
        send_sample(sample_t'(-32768), 1'b0);
        send_sample(16'sh5555, 1'b0);
        send_sample(-16'sh5556, 1'b0);
        write_window(cfg_word_t'(0));
        send_sample(sample_t'(-7), 1'b1);
        send_sample(sample_t'(-8), 1'b0);
    endtask

    // oversize window clamps to the depth; falling run fills the deque
    task automatic test_full_depth();
        write_window(cfg_word_t'(127));
        for (int i = 0; i < 72; i++)
            send_sample(sample_t'(32767 - i * 900), i == 0);
        write_window(cfg_word_t'(65));
        for (int i = 0; i < 8; i++)
            send_sample(sample_t'(-32768 + i), 1'b0);
        write_window(cfg_word_t'(WINDOW_MAX));
        for (int i = 0; i < 70; i++)
            send_sample(sample_t'(i % 5), i == 0);
    endtask

    // window size change with no restart: new size applies at once
    task automatic test_resize_mid_sequence();
        write_window(cfg_word_t'(8));
        for (int i = 0; i < 12; i++)
            send_sample(sample_t'(100 - i * 10), i == 0);
        write_window(cfg_word_t'(2));
        for (int i = 0; i < 6; i++)
            send_sample(sample_t'(-i), 1'b0);
        write_window(cfg_word_t'(10));
        for (int i = 0; i < 12; i++)
            send_sample(sample_t'(i * 3), 1'b0);
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_output_hold();
        write_window(cfg_word_t'(4));
        out_stall_on = 1'b0;
        in_gaps_on   = 1'b0;
        hold_request = 1'b1;
        wait (hold_active);
        for (int i = 0; i < 40; i++)
            send_sample(sample_t'($urandom), i == 0);
        drain_results();
        out_stall_on = 1'b1;
        in_gaps_on   = 1'b1;
    endtask

    // phases of shaped random streams under random window sizes
    task automatic test_random_stream();
        int unsigned   sent;
        int unsigned   r;
        int unsigned   win;
        int unsigned   phase_len;
        int unsigned   shape_left;
        int            prev;
        stream_shape_t shape;
        sent = 0;
        prev = 0;
        shape = SHAPE_UNIFORM;
        shape_left = 0;
        while (sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                win = $urandom_range(1, 8);
            else if (r < 85)
                win = $urandom_range(9, 24);
            else if (r < 92)
                win = $urandom_range(25, WINDOW_MAX);
            else if (r < 96)
                win = WINDOW_MAX;
            else
                win = $urandom_range(0, 127);
            write_window(cfg_word_t'(win));
            in_gaps_on   = ($urandom_range(0, 3) != 0);
            out_stall_on = ($urandom_range(0, 3) != 0);
            phase_len = ((win > WINDOW_MAX) ? WINDOW_MAX : win) + $urandom_range(10, 50);
            for (int i = 0; i < phase_len; i++)
            begin
                if (shape_left == 0)
                begin
                    shape = stream_shape_t'($urandom_range(0, 4));
                    shape_left = $urandom_range(4, 24);
                end
                shape_left--;
                prev = next_sample(shape, prev);
                send_sample(sample_t'(prev),
                            (i == 0) ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 99) < 3));
                sent++;
            end
        end
        in_gaps_on   = 1'b1;
        out_stall_on = 1'b1;
    endtask

    // main sequence
    initial
    begin
        rst_n                       <= 1'b0;
        cfg_we                      <= 1'b0;
        cfg_wdata                   <= '0;
        sample_ch.valid             <= 1'b0;
        sample_ch.sample            <= '0;
        sample_ch.start_of_sequence <= 1'b0;
        window_reg     = cfg_word_t'(swm_pkg::WINDOW_RESET);
        dq_len         = 0;
        seq_samples    = 0;
        requests_sent  = 0;
        mismatch_count = 0;
        in_gaps_on     = 1'b1;
        out_stall_on   = 1'b1;
        hold_request   = 1'b0;
        hold_active    = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_window();
        test_tiny_windows();
        test_full_depth();
        test_resize_mid_sequence();
        test_output_hold();
        test_random_stream();
        drain_results();

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/swm_pkg.sv
rtl/swm_if.sv
rtl/swm_cell.sv
rtl/sliding_window_maximum_top.sv
test/tb_top.sv
